@@ src/gnm_pkg.sv @@
`default_nettype none
package gnm_pkg;
  localparam int MaxCand = 256;
  localparam int MaxPairs = 1024;
  localparam int IdBits = 16;
  localparam int CandAw = $clog2(MaxCand);
  localparam int PairAw = $clog2(MaxPairs);
  localparam int CCntW = $clog2(MaxCand + 1);
  localparam int PCntW = $clog2(MaxPairs + 1);
  localparam int IdSpace = 1 << IdBits;
  localparam int CandW = 8 + 13 + 13 + IdBits;

  localparam logic [27:0] NearSq = 28'd400;
  localparam logic [27:0] WideSq = 28'd900;
  localparam logic [27:0] FarSq = 28'd625;
  localparam logic [27:0] MidSq = 28'd324;
  localparam logic [27:0] CloseSq = 28'd100;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_MATCH = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_MATCHED = 3'd0,
    ST_PAIRED  = 3'd1,
    ST_FAR     = 3'd2,
    ST_AMBIG   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PREAD, S_PCHK, S_CREAD, S_TREAD, S_DIST, S_ACC, S_DECIDE,
    S_OUT, S_CLRMAP
  } fsm_t;
endpackage
`default_nettype wire

@@ src/gnm_ram.sv @@
`default_nettype none
module gnm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/gnm_dist.sv @@
`default_nettype none
// Shared squared-distance unit: one registered square per cycle; the caller forms the sum.
module gnm_dist import gnm_pkg::*; (
  input  wire logic        clk,
  input  wire logic [12:0] a,
  input  wire logic [12:0] b,
  output logic      [26:0] sq_r
);
  logic [12:0] diff;
  logic [26:0] sq_nxt;

  always_comb begin
    diff = (a >= b) ? (a - b) : (b - a);
    sq_nxt = {14'd0, diff} * {14'd0, diff};
  end

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
  end
endmodule
`default_nettype wire

@@ src/gated_nearest_match.sv @@
`default_nettype none
// Nearest-candidate matcher. Loads, clears and action-3 items are taken in
// the idle state. A match request first scans the pair table, reading and
// checking each recorded pair, and stops there if one holds its external id;
// else it scans the candidates through the candidate RAM, the taken-map RAM
// and one shared squarer: an untaken candidate of the requested kind passes
// S_CREAD, S_TREAD, S_DIST and S_ACC, a taken one stops after S_DIST and one
// of another kind after S_TREAD. A last S_CREAD ends the scan, S_DECIDE
// decides and S_OUT delivers the result, which waits there while an earlier
// result is still unaccepted. After reset the block sweeps the 65536-entry
// taken map, one entry a cycle, before it accepts its first request.
module gated_nearest_match import gnm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // action[1:0], unit_kind[9:2], pos_x[22:10], pos_y[35:23],
  // internal_id[51:36], external_id[83:52], zero pad
  input  wire logic [87:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // request_id[31:0], found_id[47:32], status[50:48], zero pad
  output logic      [55:0] out_tdata
);
  fsm_t state_r, state_nxt;
  logic [CCntW-1:0] ccnt_r, ccnt_nxt;
  logic [PCntW-1:0] pcnt_r, pcnt_nxt;
  logic [PCntW-1:0] idx_r, idx_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [12:0] px_r, px_nxt, py_r, py_nxt;
  logic [31:0] ext_r, ext_nxt;
  logic        have_r, have_nxt;
  logic [27:0] best_r, best_nxt, dsum_r, dsum_nxt;
  logic [IdBits-1:0] bid_r, bid_nxt;
  logic [CCntW-1:0] near_r, near_nxt, wide_r, wide_nxt;
  logic [IdBits-1:0] clr_r, clr_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [31:0] oreq_r, oreq_nxt;
  logic [15:0] ofound_r, ofound_nxt;
  status_t     ostat_r, ostat_nxt;
  logic [15:0] rfound_r, rfound_nxt;
  status_t     rstat_r, rstat_nxt;

  action_t act;
  logic [7:0]  in_kind;
  logic [12:0] in_x, in_y;
  logic [15:0] in_iid;
  logic [31:0] in_ext;
  assign act = action_t'(in_tdata[1:0]);
  assign in_kind = in_tdata[9:2];
  assign in_x = in_tdata[22:10];
  assign in_y = in_tdata[35:23];
  assign in_iid = in_tdata[51:36];
  assign in_ext = in_tdata[83:52];

  // Candidate RAM: kind, x, y, id packed.
  logic              c_we;
  logic [CandAw-1:0] c_raddr;
  logic [CandW-1:0]  c_rdata;
  gnm_ram #(.Width(CandW), .Depth(MaxCand)) u_cand (
    .clk(clk), .we(c_we), .waddr(ccnt_r[CandAw-1:0]),
    .wdata({in_kind, in_x, in_y, in_iid[IdBits-1:0]}),
    .raddr(c_raddr), .rdata(c_rdata)
  );
  logic [7:0]  c_kind;
  logic [12:0] c_x, c_y;
  logic [IdBits-1:0] c_id;
  assign {c_kind, c_x, c_y, c_id} = c_rdata;

  logic              p_we;
  logic [PairAw-1:0] p_raddr;
  logic [31+IdBits+1-1:0] p_rdata;
  logic [31:0]       p_ext;
  logic [IdBits-1:0] p_int;
  gnm_ram #(.Width(32 + IdBits), .Depth(MaxPairs)) u_pair (
    .clk(clk), .we(p_we), .waddr(pcnt_r[PairAw-1:0]),
    .wdata({ext_r, bid_r}), .raddr(p_raddr), .rdata(p_rdata)
  );
  assign {p_ext, p_int} = p_rdata;

  logic              t_we;
  logic [IdBits-1:0] t_waddr, t_raddr;
  logic              t_wdata, t_rdata;
  gnm_ram #(.Width(1), .Depth(IdSpace)) u_taken (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  logic [12:0] d_a, d_b;
  logic [26:0] d_sq;
  gnm_dist u_dist (.clk(clk), .a(d_a), .b(d_b), .sq_r(d_sq));

  logic [CCntW-1:0] cidx;
  assign cidx = idx_r[CCntW-1:0];

  always_comb begin
    state_nxt = state_r;
    ccnt_nxt = ccnt_r;   pcnt_nxt = pcnt_r;  idx_nxt = idx_r;
    kind_nxt = kind_r;   px_nxt = px_r;      py_nxt = py_r;   ext_nxt = ext_r;
    have_nxt = have_r;   best_nxt = best_r;  bid_nxt = bid_r; dsum_nxt = dsum_r;
    near_nxt = near_r;   wide_nxt = wide_r;  clr_nxt = clr_r;
    ovalid_nxt = ovalid_r; oreq_nxt = oreq_r; ofound_nxt = ofound_r;
    ostat_nxt = ostat_r;
    rfound_nxt = rfound_r; rstat_nxt = rstat_r;
    in_tready = 1'b0;
    c_we = 1'b0; p_we = 1'b0; t_we = 1'b0;
    t_waddr = bid_r; t_wdata = 1'b1;
    c_raddr = cidx[CandAw-1:0];
    p_raddr = idx_r[PairAw-1:0];
    t_raddr = c_id;
    d_a = c_x; d_b = px_r;
    if (out_tready) ovalid_nxt = 1'b0;
    case (state_r)
      S_CLRMAP: begin
        t_we = 1'b1;
        t_waddr = clr_r;
        t_wdata = 1'b0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {IdBits{1'b1}}) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (act)
            ACT_CLEAR: ccnt_nxt = '0;
            ACT_LOAD: begin
              if (ccnt_r < CCntW'(MaxCand)) begin
                c_we = 1'b1;
                ccnt_nxt = ccnt_r + 1'b1;
              end
            end
            ACT_MATCH: begin
              kind_nxt = in_kind; px_nxt = in_x; py_nxt = in_y; ext_nxt = in_ext;
              idx_nxt = '0; have_nxt = 1'b0; near_nxt = '0; wide_nxt = '0;
              bid_nxt = '0; best_nxt = '0;
              state_nxt = S_PREAD;
            end
            default: ;
          endcase
        end
      end
      S_PREAD: begin
        if (idx_r >= pcnt_r) begin
          idx_nxt = '0;
          state_nxt = S_CREAD;
        end else begin
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        if (p_ext == ext_r) begin
          rfound_nxt = 16'(p_int);
          rstat_nxt = ST_PAIRED;
          state_nxt = S_OUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_PREAD;
        end
      end
      S_CREAD: begin
        if (cidx >= ccnt_r) state_nxt = S_DECIDE;
        else state_nxt = S_TREAD;
      end
      S_TREAD: begin
        // Candidate data is valid; look up its taken bit, square dx.
        if (c_kind != kind_r) begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_CREAD;
        end else begin
          state_nxt = S_DIST;
        end
      end
      S_DIST: begin
        d_a = c_y; d_b = py_r;
        dsum_nxt = {1'b0, d_sq};
        if (t_rdata) begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_CREAD;
        end else begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        dsum_nxt = dsum_r + {1'b0, d_sq};
        if (dsum_nxt < NearSq) near_nxt = near_r + 1'b1;
        if (dsum_nxt < WideSq) wide_nxt = wide_r + 1'b1;
        if (!have_r || dsum_nxt < best_r) begin
          have_nxt = 1'b1;
          best_nxt = dsum_nxt;
          bid_nxt = c_id;
        end
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_CREAD;
      end
      S_DECIDE: begin
        rfound_nxt = '0;
        state_nxt = S_OUT;
        if (!have_r || best_r > FarSq) rstat_nxt = ST_FAR;
        else if ((best_r > MidSq && wide_r > CCntW'(1)) ||
                 (best_r <= MidSq && best_r > CloseSq && near_r > CCntW'(1)))
          rstat_nxt = ST_AMBIG;
        else if (bid_r == '0) rstat_nxt = ST_FAR;
        else if (pcnt_r >= PCntW'(MaxPairs)) rstat_nxt = ST_FULL;
        else begin
          rstat_nxt = ST_MATCHED;
          rfound_nxt = 16'(bid_r);
          p_we = 1'b1;
          t_we = 1'b1;
          pcnt_nxt = pcnt_r + 1'b1;
        end
      end
      S_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          oreq_nxt = ext_r;
          ofound_nxt = rfound_r;
          ostat_nxt = rstat_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLRMAP;
      ccnt_r <= '0;
      pcnt_r <= '0;
      clr_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ccnt_r <= ccnt_nxt;
      pcnt_r <= pcnt_nxt;
      clr_r <= clr_nxt;
      ovalid_r <= ovalid_nxt;
    end
    idx_r <= idx_nxt;   kind_r <= kind_nxt; px_r <= px_nxt;   py_r <= py_nxt;
    ext_r <= ext_nxt;   have_r <= have_nxt; best_r <= best_nxt;
    bid_r <= bid_nxt;   dsum_r <= dsum_nxt; near_r <= near_nxt;
    wide_r <= wide_nxt; oreq_r <= oreq_nxt; ofound_r <= ofound_nxt;
    ostat_r <= ostat_nxt;
    rfound_r <= rfound_nxt; rstat_r <= rstat_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {5'd0, ostat_r, ofound_r, oreq_r};
endmodule
`default_nettype wire
